@@ hw/rtl/rsr_pkg.sv @@
// ----------------------------------------------------------------------------
// rsr_pkg: shared types and constants
// Widths, mode codes and control structs for the row statistics reducer.
// ----------------------------------------------------------------------------
`default_nettype none
package rsr_pkg;
  localparam int unsigned ROW_MAX = 256;
  localparam int unsigned CNT_W = $clog2(ROW_MAX + 1);
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned MEASURE_W = 64;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned SQ_W = 56;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'd1;

  typedef enum logic [2:0] {
    MODE_SUM = 3'd0, MODE_MEAN = 3'd1, MODE_VAR = 3'd2, MODE_STD = 3'd3,
    MODE_NORM = 3'd4, MODE_MAX = 3'd5, MODE_MIN = 3'd6, MODE_MEDIAN = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACC, ST_MUL, ST_DIV, ST_ROOT, ST_OUT
  } state_t;

  // command broadcast along the sorting chain
  typedef struct packed {
    logic                       insert;
    logic                       clear;
    logic signed [SAMPLE_W-1:0] value;
  } chain_cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/rsr_stream_if.sv @@
// ----------------------------------------------------------------------------
// rsr_stream_if: valid/ready stream channel
// Carries one payload word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface rsr_stream_if #(parameter int unsigned W = 24) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rsr_cell.sv @@
// ----------------------------------------------------------------------------
// rsr_cell: one sorting cell
// Holds one sample; shifts up when the new sample is smaller than its value.
// ----------------------------------------------------------------------------
`default_nettype none
module rsr_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rsr_pkg::chain_cmd_t                cmd,
  input  wire logic                               left_full,
  input  wire logic signed [rsr_pkg::SAMPLE_W-1:0] left_value,
  input  wire logic                               left_greater,
  output logic                                    full,
  output logic signed [rsr_pkg::SAMPLE_W-1:0]     value,
  output logic                                    greater
);
  // greater: this cell holds a value above the incoming sample
  assign greater = full && (value > cmd.value);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      full <= 1'b0;
    end else if (cmd.insert) begin
      if (greater) begin
        value <= left_greater ? left_value : cmd.value;
        full <= 1'b1;
      end else if (!full && left_full) begin
        // first empty cell: takes the shifted value or the new sample
        value <= left_greater ? left_value : cmd.value;
        full <= 1'b1;
      end
    end
  end

  // unused left_value when left is not greater is fine
endmodule
`default_nettype wire

@@ hw/rtl/rsr_chain.sv @@
// ----------------------------------------------------------------------------
// rsr_chain: row of sorting cells
// Keeps the samples of the current row in ascending order, one per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rsr_chain (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rsr_pkg::chain_cmd_t                 cmd,
  input  wire logic [rsr_pkg::CNT_W-1:0]           pick,
  output logic signed [rsr_pkg::SAMPLE_W-1:0]      picked
);
  localparam int unsigned N = rsr_pkg::ROW_MAX;
  logic                               full [N];
  logic signed [rsr_pkg::SAMPLE_W-1:0] vals [N];
  logic                               gt   [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    rsr_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd),
      .left_full(i == 0 ? 1'b1 : full[(i == 0) ? 0 : i-1]),
      .left_value(vals[(i == 0) ? 0 : i-1]),
      .left_greater(i == 0 ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .full(full[i]), .value(vals[i]), .greater(gt[i])
    );
  end

  always_ff @(posedge clk) begin
    picked <= vals[pick[$clog2(N)-1:0]];
  end
endmodule
`default_nettype wire

@@ hw/rtl/rsr_root.sv @@
// ----------------------------------------------------------------------------
// rsr_root: restoring divider and square root
// Shared iterative unit: one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rsr_root (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        is_root,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      res
);
  logic [6:0]  step;
  logic        busy;
  logic        root;
  logic [63:0] n_sh;
  logic [65:0] rem;
  logic [63:0] d;
  logic [65:0] trial;
  logic [65:0] rem_sh;

  always_comb begin
    if (root) begin
      rem_sh = {rem[63:0], n_sh[63:62]};
      trial  = {res, 2'b01};
    end else begin
      rem_sh = {rem[64:0], n_sh[63]};
      trial  = {2'b00, d};
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1; root <= is_root; n_sh <= num; d <= den;
      rem <= '0; res <= '0; step <= is_root ? 7'd32 : 7'd64;
    end else if (busy) begin
      n_sh <= root ? {n_sh[61:0], 2'b00} : {n_sh[62:0], 1'b0};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial; res <= {res[62:0], 1'b1};
      end else begin
        rem <= rem_sh; res <= {res[62:0], 1'b0};
      end
      step <= step - 7'd1;
      if (step == 7'd1) begin
        busy <= 1'b0; done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/row_statistics_reducer.sv @@
// ----------------------------------------------------------------------------
// row_statistics_reducer: per-row statistic of a sample stream
// Sum, mean, variance, std dev, norm, max, min or median of each row.
// ----------------------------------------------------------------------------
// channel    dir  payload         width
// samples    in   sample          24 signed, 8 fraction bits
// measures   out  measure         64 signed, 8 fraction bits
// cfg        in   cfg_we/idx/data register writes, no read-back
//
// mid-row samples are taken one per cycle into the accumulators and the
// sorting chain; the closing sample starts the result path: a product stage,
// then the shared bit-serial divider (mean, variance), root (norm) or both (std dev)
// no new sample is taken until the measure has been transferred
// synchronous reset clears counters, accumulators and the chain's full bits
// ----------------------------------------------------------------------------
`default_nettype none
module row_statistics_reducer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  rsr_stream_if.sink                          samples,
  rsr_stream_if.source                        measures,
  input  wire logic                           cfg_we,
  input  wire logic [rsr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rsr_pkg::CFG_DATA_W-1:0] cfg_data
);
  rsr_pkg::state_t state, state_next;
  rsr_pkg::mode_t  mode;
  logic [8:0]      row_length;
  logic [rsr_pkg::CNT_W-1:0] count;
  logic signed [rsr_pkg::SUM_W-1:0]    sum;
  logic [rsr_pkg::SQ_W-1:0]            sq;
  logic signed [rsr_pkg::SAMPLE_W-1:0] extreme;
  logic signed [rsr_pkg::SAMPLE_W-1:0] x;
  logic [rsr_pkg::CNT_W-1:0] n;
  logic [rsr_pkg::CNT_W-1:0] eff_len;
  logic [rsr_pkg::CNT_W-1:0] count_inc;
  logic accept, closing;
  rsr_pkg::chain_cmd_t cmd;

  // closing-row snapshot
  logic signed [rsr_pkg::SUM_W-1:0] s_sum;
  logic [63:0] nq, ss, dv, spread;
  logic [rsr_pkg::CNT_W-1:0] pick;
  logic signed [rsr_pkg::SAMPLE_W-1:0] picked, low_mid;
  logic [2:0] med_phase;
  logic        div_start, root_start, unit_done, is_root;
  logic [63:0] unit_num, unit_den, unit_res;
  logic [63:0] out_data;
  logic        out_valid;
  logic [31:0] s_mag;
  logic        mul_ready;

  assign x = samples.data;
  assign samples.ready = (state == rsr_pkg::ST_ACC);
  assign accept = samples.valid && samples.ready;
  assign count_inc = (count < rsr_pkg::CNT_W'(rsr_pkg::ROW_MAX)) ? count + 1'b1 : count;
  always_comb begin
    if (row_length == 9'd0) eff_len = rsr_pkg::CNT_W'(1);
    else if ({1'b0, row_length} > 10'(rsr_pkg::ROW_MAX)) eff_len = rsr_pkg::CNT_W'(rsr_pkg::ROW_MAX);
    else eff_len = rsr_pkg::CNT_W'(row_length);
  end
  assign closing = accept && (count_inc >= eff_len);

  assign cmd.insert = accept;
  assign cmd.clear  = 1'b0;
  assign cmd.value  = x;

  rsr_chain u_chain (.clk(clk), .rst(rst || (out_valid && measures.ready)),
    .cmd(cmd), .pick(pick), .picked(picked));

  rsr_root u_root (.clk(clk), .rst(rst), .start(div_start || root_start),
    .is_root(is_root), .num(unit_num), .den(unit_den), .done(unit_done), .res(unit_res));

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= rsr_pkg::MODE_SUM; row_length <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        rsr_pkg::REG_MODE:       mode <= rsr_pkg::mode_t'(cfg_data[2:0]);
        rsr_pkg::REG_ROW_LENGTH: row_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (rst || (out_valid && measures.ready)) begin
      count <= '0; sum <= '0; sq <= '0; extreme <= '0;
    end else if (accept) begin
      count <= count_inc;
      sum <= sum + rsr_pkg::SUM_W'(x);
      sq  <= sq + rsr_pkg::SQ_W'(unsigned'(48'(x) * 48'(x)));
      if (count == '0) extreme <= x;
      else if (mode == rsr_pkg::MODE_MAX && x > extreme) extreme <= x;
      else if (mode == rsr_pkg::MODE_MIN && x < extreme) extreme <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rsr_pkg::ST_ACC;
    else state <= state_next;
  end

  assign s_mag = s_sum[31] ? 32'(-s_sum) : 32'(s_sum);
  assign spread = nq - ss;

  // result path registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; med_phase <= '0;
    end else begin
      if (out_valid && measures.ready) out_valid <= 1'b0;
      case (state)
        rsr_pkg::ST_ACC: if (closing) begin
          n <= count_inc;
          s_sum <= sum + rsr_pkg::SUM_W'(x);
          pick <= count_inc >> 1;
          med_phase <= '0;
        end
        rsr_pkg::ST_MUL: begin
          // products of the closing row
          nq <= 64'(n) * 64'(sq);
          ss <= 64'(s_mag) * 64'(s_mag);
          dv <= 64'(n) * 64'(n - 1'b1);
          if (mode == rsr_pkg::MODE_MEDIAN) begin
            med_phase <= med_phase + 1'b1;
            if (med_phase == 3'd0) begin
              pick <= n >> 1;
            end else if (med_phase == 3'd1) begin
              pick <= (n >> 1) - 1'b1;
            end else if (med_phase == 3'd2) begin
              low_mid <= picked;
            end else begin
              out_valid <= 1'b1;
              out_data <= n[0] ? 64'(signed'(low_mid))
                : 64'((65'(signed'(low_mid)) + 65'(signed'(picked))) >>> 1);
            end
          end
        end
        // std dev goes on to the root, the others finish here
        rsr_pkg::ST_DIV: if (unit_done && mode != rsr_pkg::MODE_STD) begin
          out_valid <= 1'b1;
          out_data <= (mode == rsr_pkg::MODE_MEAN && s_sum[31]) ? -unit_res : unit_res;
        end
        rsr_pkg::ST_ROOT: if (unit_done) begin
          out_valid <= 1'b1; out_data <= unit_res;
        end
        default: ;
      endcase
      if (state == rsr_pkg::ST_MUL && state_next == rsr_pkg::ST_OUT
          && mode != rsr_pkg::MODE_MEDIAN) begin
        out_valid <= 1'b1;
        case (mode)
          rsr_pkg::MODE_SUM: out_data <= 64'(s_sum);
          rsr_pkg::MODE_MAX, rsr_pkg::MODE_MIN: out_data <= 64'(extreme);
          default: out_data <= '0;
        endcase
      end
    end
  end

  // divider/root operand selection, once the products have settled
  always_comb begin
    div_start = 1'b0; root_start = 1'b0; is_root = 1'b0;
    unit_num = '0; unit_den = 64'd1;
    if (state == rsr_pkg::ST_MUL && mul_ready) begin
      case (mode)
        rsr_pkg::MODE_MEAN: begin
          div_start = 1'b1; unit_num = 64'(s_mag); unit_den = 64'(n);
        end
        rsr_pkg::MODE_VAR: if (n > 1) begin
          div_start = 1'b1; unit_num = spread; unit_den = {dv[55:0], 8'h00};
        end
        rsr_pkg::MODE_STD: if (n > 1) begin
          div_start = 1'b1; unit_num = spread; unit_den = dv;
        end
        rsr_pkg::MODE_NORM: begin
          root_start = 1'b1; is_root = 1'b1; unit_num = 64'(sq);
        end
        default: ;
      endcase
    end
    if (state == rsr_pkg::ST_DIV && unit_done && mode == rsr_pkg::MODE_STD) begin
      root_start = 1'b1; is_root = 1'b1; unit_num = unit_res;
    end
  end

  // next state: outside median mode, ST_MUL waits for mul_ready so its products settle before use
  always_ff @(posedge clk) begin
    if (rst) mul_ready <= 1'b0;
    else mul_ready <= (state == rsr_pkg::ST_MUL) && !mul_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      rsr_pkg::ST_ACC: if (closing) state_next = rsr_pkg::ST_MUL;
      rsr_pkg::ST_MUL: begin
        if (mode == rsr_pkg::MODE_MEDIAN) begin
          if (med_phase == 3'd3) state_next = rsr_pkg::ST_OUT;
        end else if (mul_ready) begin
          if (mode == rsr_pkg::MODE_NORM) state_next = rsr_pkg::ST_ROOT;
          else if (mode == rsr_pkg::MODE_MEAN) state_next = rsr_pkg::ST_DIV;
          else if ((mode == rsr_pkg::MODE_VAR || mode == rsr_pkg::MODE_STD) && n > 1)
            state_next = rsr_pkg::ST_DIV;
          else state_next = rsr_pkg::ST_OUT;
        end
      end
      rsr_pkg::ST_DIV: if (unit_done)
        state_next = (mode == rsr_pkg::MODE_STD) ? rsr_pkg::ST_ROOT : rsr_pkg::ST_OUT;
      rsr_pkg::ST_ROOT: if (unit_done && !root_start) state_next = rsr_pkg::ST_OUT;
      rsr_pkg::ST_OUT: if (measures.valid && measures.ready) state_next = rsr_pkg::ST_ACC;
      default: state_next = rsr_pkg::ST_ACC;
    endcase
  end

  assign measures.valid = out_valid;
  assign measures.data  = out_data;

  // no sample transfer while a measure is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !samples.ready) else $error("sample taken with measure pending");
  // count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rsr_pkg::CNT_W'(rsr_pkg::ROW_MAX)) else $error("count overflow");
  // transfer of a measure returns to accumulation
  a_return: assert property (@(posedge clk) disable iff (rst)
    (out_valid && measures.ready) |=> (state == rsr_pkg::ST_ACC)) else $error("no return");
endmodule
`default_nettype wire
